// ----- sv/ialu_pkg.sv -----
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_SDIV = 5'd3,
        OP_SMOD = 5'd4,
        OP_EQ   = 5'd5,
        OP_NE   = 5'd6,
        OP_LT   = 5'd7,
        OP_LE   = 5'd8,
        OP_GT   = 5'd9,
        OP_GE   = 5'd10,
        OP_BAND = 5'd11,
        OP_BOR  = 5'd12,
        OP_BXOR = 5'd13,
        OP_SHL  = 5'd14,
        OP_SAR  = 5'd15,
        OP_LAND = 5'd16,
        OP_LOR  = 5'd17,
        OP_UDIV = 5'd18,
        OP_UMOD = 5'd19,
        OP_LTU  = 5'd20,
        OP_LEU  = 5'd21,
        OP_GTU  = 5'd22,
        OP_GEU  = 5'd23,
        OP_SHR  = 5'd24,
        OP_NEG  = 5'd25,
        OP_BNOT = 5'd26,
        OP_LNOT = 5'd27
    } op_t;

    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_BOOL = 2'd1;

    typedef struct packed {
        op_t  op;
        logic ok;
        logic kind;
        logic qneg;
        logic rneg;
    } ctl_t;

endpackage

// ----- sv/ialu_exec.sv -----
module ialu_exec import ialu_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF,
    parameter int H = (W + 1) / 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            vld_in,
    input  op_t             op,
    input  logic [1:0]      k1,
    input  logic [1:0]      k2,
    input  logic [63:0]     a_in,
    input  logic [63:0]     b_in,
    output logic            vld_reg,
    output ctl_t            ctl_reg,
    output logic [W-1:0]    val_reg,
    output logic [2*H-1:0]  pll_reg,
    output logic [W-1:0]    px1_reg,
    output logic [W-1:0]    px2_reg,
    output logic [W-1:0]    dvd_reg,
    output logic [W-1:0]    dvs_reg
);

    localparam logic [6:0] WL = 7'(W);

    logic [W-1:0] aw;
    logic [W-1:0] bw;
    logic [W-1:0] minw;
    logic [W-1:0] ma;
    logic [W-1:0] mb;
    logic [5:0]   amt;
    logic         big;
    logic         ints;
    logic         bools;
    ctl_t         ctl_next;
    logic [W-1:0] val_next;
    logic [W-1:0] dvd_next;
    logic [W-1:0] dvs_next;

    always_comb
    begin
        aw    = a_in[W-1:0];
        bw    = b_in[W-1:0];
        minw  = {1'b1, {(W-1){1'b0}}};
        ma    = aw[W-1] ? (~aw + 1'b1) : aw;
        mb    = bw[W-1] ? (~bw + 1'b1) : bw;
        amt   = b_in[5:0];
        big   = {1'b0, amt} >= WL;
        ints  = (k1 == KIND_INT) && (k2 == KIND_INT);
        bools = (k1 == KIND_BOOL) && (k2 == KIND_BOOL);

        ctl_next.op   = op;
        ctl_next.ok   = ints;
        ctl_next.kind = 1'b0;
        ctl_next.qneg = aw[W-1] ^ bw[W-1];
        ctl_next.rneg = aw[W-1];
        val_next      = '0;
        dvd_next      = aw;
        dvs_next      = bw;

        unique case (op)
            OP_ADD:  val_next = aw + bw;
            OP_SUB:  val_next = aw - bw;
            OP_MUL:  val_next = '0;
            OP_SDIV, OP_SMOD:
            begin
                ctl_next.ok = ints && (bw != '0) && !((aw == minw) && (bw == '1));
                dvd_next    = ma;
                dvs_next    = mb;
            end
            OP_UDIV, OP_UMOD: ctl_next.ok = ints && (bw != '0);
            OP_EQ:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'(aw == bw);
            end
            OP_NE:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'(aw != bw);
            end
            OP_LT:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'($signed(aw) < $signed(bw));
            end
            OP_LE:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'($signed(aw) <= $signed(bw));
            end
            OP_GT:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'($signed(aw) > $signed(bw));
            end
            OP_GE:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'($signed(aw) >= $signed(bw));
            end
            OP_LTU:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'(aw < bw);
            end
            OP_LEU:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'(aw <= bw);
            end
            OP_GTU:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'(aw > bw);
            end
            OP_GEU:
            begin
                ctl_next.kind = 1'b1;
                val_next      = W'(aw >= bw);
            end
            OP_BAND: val_next = aw & bw;
            OP_BOR:  val_next = aw | bw;
            OP_BXOR: val_next = aw ^ bw;
            OP_SHL:  val_next = big ? '0 : (aw << amt);
            OP_SHR:  val_next = big ? '0 : (aw >> amt);
            OP_SAR:  val_next = big ? {W{aw[W-1]}} : W'($signed(aw) >>> amt);
            OP_LAND:
            begin
                ctl_next.ok   = bools;
                ctl_next.kind = 1'b1;
                val_next      = W'(a_in[0] & b_in[0]);
            end
            OP_LOR:
            begin
                ctl_next.ok   = bools;
                ctl_next.kind = 1'b1;
                val_next      = W'(a_in[0] | b_in[0]);
            end
            OP_NEG:
            begin
                ctl_next.ok = (k1 == KIND_INT);
                val_next    = ~aw + 1'b1;
            end
            OP_BNOT:
            begin
                ctl_next.ok = (k1 == KIND_INT);
                val_next    = ~aw;
            end
            OP_LNOT:
            begin
                ctl_next.ok   = (k1 == KIND_BOOL);
                ctl_next.kind = 1'b1;
                val_next      = W'(!a_in[0]);
            end
            default: ctl_next.ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    // results, plus three half-width partial products of the low W bits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_next;
            val_reg <= val_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_next;
            pll_reg <= aw[H-1:0] * bw[H-1:0];
            px1_reg <= W'(aw[H-1:0] * bw[W-1:H]);
            px2_reg <= W'(aw[W-1:H] * bw[H-1:0]);
        end
    end

endmodule

// ----- sv/ialu_div_step.sv -----
module ialu_div_step import ialu_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          vld_in,
    input  ctl_t          ctl_in,
    input  logic [W-1:0]  val_in,
    input  logic [W-1:0]  rem_in,
    input  logic [W-1:0]  quo_in,
    input  logic [W-1:0]  dvs_in,
    output logic          vld_reg,
    output ctl_t          ctl_reg,
    output logic [W-1:0]  val_reg,
    output logic [W-1:0]  rem_reg,
    output logic [W-1:0]  quo_reg,
    output logic [W-1:0]  dvs_reg
);

    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {rem_in, quo_in[W-1]};
        diff     = trial - {1'b0, dvs_in};
        ge       = !diff[W];
        rem_next = ge ? diff[W-1:0] : trial[W-1:0];
        quo_next = {quo_in[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg <= ctl_in;
            val_reg <= val_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvs_reg <= dvs_in;
        end
    end

endmodule

// ----- sv/int64_alu_with_fold_check.sv -----
// Pipelined 64-bit integer/boolean ALU with fold check. One operation is
// accepted every cycle unless stalled, and each gives exactly one result,
// in order, through an input register, an execute stage (simple ops and
// the three half-width partial products of the multiply), a multiply sum
// stage, DATA_WIDTH one-bit restoring divide steps that every item passes
// through, and the output register that applies the divide signs and the
// sign extension. The whole pipeline advances together; it holds when the
// output register is full and not taken, so no transfer is lost or repeated.
module int64_alu_with_fold_check import ialu_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [4:0]   operation,
    input  logic [1:0]   first_kind,
    input  logic [63:0]  first_value,
    input  logic [1:0]   second_kind,
    input  logic [63:0]  second_value,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         folded,
    output logic         result_kind,
    output logic [63:0]  result_value
);

    localparam int W = DATA_WIDTH;
    localparam int H = (W + 1) / 2;

    logic adv;

    // input register
    logic        s0_vld_reg;
    op_t         s0_op_reg;
    logic [1:0]  s0_k1_reg;
    logic [1:0]  s0_k2_reg;
    logic [63:0] s0_a_reg;
    logic [63:0] s0_b_reg;

    // execute stage
    logic           s1_vld;
    ctl_t           s1_ctl;
    logic [W-1:0]   s1_val;
    logic [2*H-1:0] s1_pll;
    logic [W-1:0]   s1_px1;
    logic [W-1:0]   s1_px2;
    logic [W-1:0]   s1_dvd;
    logic [W-1:0]   s1_dvs;

    // multiply sum stage
    logic         s2_vld_reg;
    ctl_t         s2_ctl_reg;
    logic [W-1:0] s2_val_reg;
    logic [W-1:0] s2_dvd_reg;
    logic [W-1:0] s2_dvs_reg;
    logic [W-1:0] s2_val_next;

    // divide chain
    logic         dv_vld [0:W];
    ctl_t         dv_ctl [0:W];
    logic [W-1:0] dv_val [0:W];
    logic [W-1:0] dv_rem [0:W];
    logic [W-1:0] dv_quo [0:W];
    logic [W-1:0] dv_dvs [0:W];

    // output register
    logic         out_valid_reg;
    logic         folded_reg;
    logic         result_kind_reg;
    logic [63:0]  result_value_reg;
    logic [W-1:0] fin_v;
    logic [63:0]  result_value_next;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_op_reg <= op_t'(operation);
            s0_k1_reg <= first_kind;
            s0_k2_reg <= second_kind;
            s0_a_reg  <= first_value;
            s0_b_reg  <= second_value;
        end
    end

    ialu_exec #(.W(W), .H(H)) u_exec (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (s0_vld_reg),
        .op      (s0_op_reg),
        .k1      (s0_k1_reg),
        .k2      (s0_k2_reg),
        .a_in    (s0_a_reg),
        .b_in    (s0_b_reg),
        .vld_reg (s1_vld),
        .ctl_reg (s1_ctl),
        .val_reg (s1_val),
        .pll_reg (s1_pll),
        .px1_reg (s1_px1),
        .px2_reg (s1_px2),
        .dvd_reg (s1_dvd),
        .dvs_reg (s1_dvs)
    );

    always_comb
    begin
        if (s1_ctl.op == OP_MUL)
        begin
            s2_val_next = s1_pll[W-1:0] + W'(s1_px1 << H) + W'(s1_px2 << H);
        end
        else
        begin
            s2_val_next = s1_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_ctl_reg <= s1_ctl;
            s2_val_reg <= s2_val_next;
            s2_dvd_reg <= s1_dvd;
            s2_dvs_reg <= s1_dvs;
        end
    end

    assign dv_vld[0] = s2_vld_reg;
    assign dv_ctl[0] = s2_ctl_reg;
    assign dv_val[0] = s2_val_reg;
    assign dv_rem[0] = '0;
    assign dv_quo[0] = s2_dvd_reg;
    assign dv_dvs[0] = s2_dvs_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_div
        ialu_div_step #(.W(W)) u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .vld_in  (dv_vld[i]),
            .ctl_in  (dv_ctl[i]),
            .val_in  (dv_val[i]),
            .rem_in  (dv_rem[i]),
            .quo_in  (dv_quo[i]),
            .dvs_in  (dv_dvs[i]),
            .vld_reg (dv_vld[i+1]),
            .ctl_reg (dv_ctl[i+1]),
            .val_reg (dv_val[i+1]),
            .rem_reg (dv_rem[i+1]),
            .quo_reg (dv_quo[i+1]),
            .dvs_reg (dv_dvs[i+1])
        );
    end

    always_comb
    begin
        unique case (dv_ctl[W].op)
            OP_SDIV: fin_v = dv_ctl[W].qneg ? (~dv_quo[W] + 1'b1) : dv_quo[W];
            OP_SMOD: fin_v = dv_ctl[W].rneg ? (~dv_rem[W] + 1'b1) : dv_rem[W];
            OP_UDIV: fin_v = dv_quo[W];
            OP_UMOD: fin_v = dv_rem[W];
            default: fin_v = dv_val[W];
        endcase

        if (!dv_ctl[W].ok)
        begin
            result_value_next = '0;
        end
        else if (dv_ctl[W].kind)
        begin
            result_value_next = {63'd0, fin_v[0]};
        end
        else
        begin
            result_value_next = 64'($signed(fin_v));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_vld[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            folded_reg       <= dv_ctl[W].ok;
            result_kind_reg  <= dv_ctl[W].ok && dv_ctl[W].kind;
            result_value_reg <= result_value_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign folded       = folded_reg;
    assign result_kind  = result_kind_reg;
    assign result_value = result_value_reg;

    a_unfolded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !folded) |-> (!result_kind && (result_value == 64'd0)))
        else $error("unfolded result not cleared");

    a_bool_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind) |-> (result_value[63:1] == 63'd0))
        else $error("boolean result out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(folded)
            && $stable(result_kind) && $stable(result_value)))
        else $error("pipeline moved during stall");

    a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted during stall");

endmodule
